[hdl/aeds_pkg.sv]
// Shared types and constants for the arcsine-in-degrees block.
// Used by every module of the block; depends on nothing.
package aeds_pkg;

  // item class picked at the front
  typedef enum logic [1:0] {
    CLS_POS90,
    CLS_NEG90,
    CLS_DIRECT,
    CLS_COMP
  } cls_t;

  // one classified item, as it moves from the front to the root pipeline
  typedef struct packed {
    cls_t               cls;
    logic signed [15:0] x;
    logic [28:0]        rad;
  } item_t;

  // configuration register file
  typedef struct packed {
    logic signed [15:0] clamp_high;
    logic signed [15:0] clamp_low;
    logic signed [15:0] band_high;
    logic signed [15:0] band_low;
    logic [15:0]        coef_cubic;
    logic [15:0]        coef_fifth;
    logic [15:0]        coef_seventh;
    logic [15:0]        coef_ninth;
  } cfg_t;

  // register indexes
  localparam logic [3:0] REG_CLAMP_HIGH   = 4'd0;
  localparam logic [3:0] REG_CLAMP_LOW    = 4'd1;
  localparam logic [3:0] REG_BAND_HIGH    = 4'd2;
  localparam logic [3:0] REG_BAND_LOW     = 4'd3;
  localparam logic [3:0] REG_COEF_CUBIC   = 4'd4;
  localparam logic [3:0] REG_COEF_FIFTH   = 4'd5;
  localparam logic [3:0] REG_COEF_SEVENTH = 4'd6;
  localparam logic [3:0] REG_COEF_NINTH   = 4'd7;

  // fixed numbers
  localparam logic signed [15:0] SMALL_HIGH     = 16'sd164;
  localparam logic signed [15:0] SMALL_LOW      = -16'sd164;
  localparam logic signed [15:0] DEG_PER_RAD_Q8 = 16'sd14668;
  localparam logic signed [29:0] NINETY_Q8      = 30'sd23040;
  localparam int                 SQRT_STEPS     = 15;

endpackage

[hdl/aeds_front.sv]
// Front end: takes command beats, classifies them, forms the root radicand
// and holds them in a two-entry queue. Depends on aeds_pkg.
module aeds_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   sine_in,
  input  aeds_pkg::cfg_t       cfg,
  output logic                 busy,
  output logic                 out_valid,
  output aeds_pkg::item_t      out_item
);

  aeds_pkg::item_t    q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;
  aeds_pkg::item_t    new_item;
  logic signed [31:0] xx;
  logic signed [32:0] diff;

  // classify and form 1 - x^2 in Q4.28, floored at zero
  always_comb begin
    xx   = sine_in * sine_in;
    diff = 33'sd268435456 - 33'(xx);
    new_item.x = sine_in;
    new_item.rad = diff[32] ? 29'd0 : diff[28:0];
    priority if (sine_in > cfg.clamp_high) begin
      new_item.cls = aeds_pkg::CLS_POS90;
    end else if (sine_in < cfg.clamp_low) begin
      new_item.cls = aeds_pkg::CLS_NEG90;
    end else if (sine_in < cfg.band_high && sine_in > cfg.band_low) begin
      new_item.cls = aeds_pkg::CLS_DIRECT;
    end else begin
      new_item.cls = aeds_pkg::CLS_COMP;
    end
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign pop       = (count != 2'd0);
  assign out_valid = pop;
  assign out_item  = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[hdl/aeds_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Carries the item's sine input and class alongside. Depends on aeds_pkg.
module aeds_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  aeds_pkg::item_t      in_item,
  output logic                 out_valid,
  output aeds_pkg::cls_t       out_cls,
  output logic signed [15:0]   out_x,
  output logic [14:0]          out_root
);

  localparam int N = aeds_pkg::SQRT_STEPS;

  logic               vld   [N];
  aeds_pkg::cls_t     cls_r [N];
  logic signed [15:0] x_r   [N];
  logic [28:0]        n_r   [N];
  logic [29:0]        root_r[N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_step
      localparam logic [29:0] BITV = 30'd1 << (28 - 2 * k);
      logic [28:0]        n_in;
      logic [29:0]        root_in;
      aeds_pkg::cls_t     cls_in;
      logic signed [15:0] x_in;
      logic               vld_in;
      logic [29:0]        trial;
      logic               take;

      if (k == 0) begin : g_first
        assign n_in    = in_item.rad;
        assign root_in = 30'd0;
        assign cls_in  = in_item.cls;
        assign x_in    = in_item.x;
        assign vld_in  = in_valid;
      end else begin : g_rest
        assign n_in    = n_r[k-1];
        assign root_in = root_r[k-1];
        assign cls_in  = cls_r[k-1];
        assign x_in    = x_r[k-1];
        assign vld_in  = vld[k-1];
      end

      // one restoring step
      assign trial = root_in + BITV;
      assign take  = ({1'b0, n_in} >= trial);

      always_ff @(posedge clk) begin
        if (take) begin
          n_r[k]    <= 29'({1'b0, n_in} - trial);
          root_r[k] <= (root_in >> 1) + BITV;
        end else begin
          n_r[k]    <= n_in;
          root_r[k] <= root_in >> 1;
        end
        cls_r[k] <= cls_in;
        x_r[k]   <= x_in;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else begin
          vld[k] <= vld_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld[N-1];
  assign out_cls   = cls_r[N-1];
  assign out_x     = x_r[N-1];
  assign out_root  = root_r[N-1][14:0];

endmodule

[hdl/aeds_series.sv]
// Back end: odd power series, radian to degree scaling, complement and
// saturation, ending in the result register. Depends on aeds_pkg.
module aeds_series (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  aeds_pkg::cls_t       in_cls,
  input  logic signed [15:0]   in_x,
  input  logic [14:0]          in_root,
  input  aeds_pkg::cfg_t       cfg,
  output logic                 done,
  output logic signed [15:0]   angle_deg
);

  typedef struct packed {
    logic               vld;
    aeds_pkg::cls_t     cls;
    logic               neg;
    logic               near_zero;
    logic signed [15:0] v;
  } ctl_t;

  ctl_t ca, cb, cc, cd, ce, cf, cg, ch;
  ctl_t c_in;

  logic signed [17:0] sqa, sqb, sqc, sqd;
  logic signed [18:0] p3b, p3c;
  logic signed [20:0] p5c, p5d;
  logic signed [22:0] p7d, p7e;
  logic signed [24:0] p9e;
  logic signed [24:0] t3c, t3d, t3e, t3f;
  logic signed [24:0] t5d, t5e, t5f;
  logic signed [24:0] t7e, t7f;
  logic signed [24:0] t9f;
  logic signed [26:0] radg;
  logic signed [28:0] degh;

  logic signed [15:0] v;
  logic signed [31:0] mv, rv;
  logic signed [33:0] m3, r3;
  logic signed [36:0] m5, r5;
  logic signed [35:0] mt3, rt3;
  logic signed [38:0] m7, r7;
  logic signed [37:0] mt5, rt5;
  logic signed [40:0] m9, r9;
  logic signed [39:0] mt7, rt7;
  logic signed [41:0] mt9, rt9;
  logic signed [26:0] sum;
  logic signed [42:0] md, rd;
  logic signed [29:0] adj;
  logic signed [15:0] fin;

  // pick the series argument
  always_comb begin
    if (in_cls == aeds_pkg::CLS_COMP) begin
      v = in_x[15] ? -$signed({1'b0, in_root}) : $signed({1'b0, in_root});
    end else begin
      v = in_x;
    end
    c_in.vld       = in_valid;
    c_in.cls       = in_cls;
    c_in.neg       = in_x[15];
    c_in.near_zero = (v < aeds_pkg::SMALL_HIGH) && (v > aeds_pkg::SMALL_LOW);
    c_in.v         = v;
    mv = v * v;
    rv = (mv + 32'sd8192) >>> 14;
  end

  // powers and terms, one multiply per path per stage
  always_comb begin
    m3  = ca.v * sqa;
    r3  = (m3 + 34'sd8192) >>> 14;
    m5  = p3b * sqb;
    r5  = (m5 + 37'sd8192) >>> 14;
    mt3 = p3b * $signed({1'b0, cfg.coef_cubic});
    rt3 = (mt3 + 36'sd32768) >>> 16;
    m7  = p5c * sqc;
    r7  = (m7 + 39'sd8192) >>> 14;
    mt5 = p5c * $signed({1'b0, cfg.coef_fifth});
    rt5 = (mt5 + 38'sd32768) >>> 16;
    m9  = p7d * sqd;
    r9  = (m9 + 41'sd8192) >>> 14;
    mt7 = p7d * $signed({1'b0, cfg.coef_seventh});
    rt7 = (mt7 + 40'sd32768) >>> 16;
    mt9 = p9e * $signed({1'b0, cfg.coef_ninth});
    rt9 = (mt9 + 42'sd32768) >>> 16;
  end

  // sum, degree scaling, complement and saturation
  always_comb begin
    sum = 27'(cf.v) + 27'(t3f) + 27'(t5f) + 27'(t7f) + 27'(t9f);
    md  = radg * aeds_pkg::DEG_PER_RAD_Q8;
    rd  = (md + 43'sd8192) >>> 14;
    if (ch.cls == aeds_pkg::CLS_COMP) begin
      adj = ch.neg ? (-aeds_pkg::NINETY_Q8 - 30'(degh))
                   : (aeds_pkg::NINETY_Q8 - 30'(degh));
    end else begin
      adj = 30'(degh);
    end
    if (adj > aeds_pkg::NINETY_Q8) begin
      fin = 16'(aeds_pkg::NINETY_Q8);
    end else if (adj < -aeds_pkg::NINETY_Q8) begin
      fin = 16'(-aeds_pkg::NINETY_Q8);
    end else begin
      fin = adj[15:0];
    end
    unique case (ch.cls)
      aeds_pkg::CLS_POS90:  fin = 16'(aeds_pkg::NINETY_Q8);
      aeds_pkg::CLS_NEG90:  fin = 16'(-aeds_pkg::NINETY_Q8);
      aeds_pkg::CLS_DIRECT,
      aeds_pkg::CLS_COMP:   fin = fin;
      default:              fin = fin;
    endcase
  end

  // datapath registers and stage valid bits
  always_ff @(posedge clk) begin
    sqa <= rv[17:0];
    p3b <= r3[18:0];
    sqb <= sqa;
    p5c <= r5[20:0];
    t3c <= 25'(rt3);
    sqc <= sqb;
    p7d <= r7[22:0];
    t5d <= 25'(rt5);
    t3d <= t3c;
    sqd <= sqc;
    p9e <= r9[24:0];
    t7e <= 25'(rt7);
    t5e <= t5d;
    t3e <= t3d;
    t9f <= 25'(rt9);
    t7f <= t7e;
    t5f <= t5e;
    t3f <= t3e;
    radg <= cf.near_zero ? 27'(cf.v) : sum;
    degh <= rd[28:0];
    angle_deg <= fin;
    ca.cls <= c_in.cls;  ca.neg <= c_in.neg;  ca.near_zero <= c_in.near_zero;  ca.v <= c_in.v;
    cb.cls <= ca.cls;    cb.neg <= ca.neg;    cb.near_zero <= ca.near_zero;    cb.v <= ca.v;
    cc.cls <= cb.cls;    cc.neg <= cb.neg;    cc.near_zero <= cb.near_zero;    cc.v <= cb.v;
    cd.cls <= cc.cls;    cd.neg <= cc.neg;    cd.near_zero <= cc.near_zero;    cd.v <= cc.v;
    ce.cls <= cd.cls;    ce.neg <= cd.neg;    ce.near_zero <= cd.near_zero;    ce.v <= cd.v;
    cf.cls <= ce.cls;    cf.neg <= ce.neg;    cf.near_zero <= ce.near_zero;    cf.v <= ce.v;
    cg.cls <= cf.cls;    cg.neg <= cf.neg;    cg.near_zero <= cf.near_zero;    cg.v <= cf.v;
    ch.cls <= cg.cls;    ch.neg <= cg.neg;    ch.near_zero <= cg.near_zero;    ch.v <= cg.v;
    if (rst) begin
      ca.vld <= 1'b0;  cb.vld <= 1'b0;  cc.vld <= 1'b0;  cd.vld <= 1'b0;
      ce.vld <= 1'b0;  cf.vld <= 1'b0;  cg.vld <= 1'b0;  ch.vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      ca.vld <= c_in.vld;
      cb.vld <= ca.vld;
      cc.vld <= cb.vld;
      cd.vld <= cc.vld;
      ce.vld <= cd.vld;
      cf.vld <= ce.vld;
      cg.vld <= cf.vld;
      ch.vld <= cg.vld;
      done   <= ch.vld;
    end
  end

endmodule

[hdl/arcsin_degrees_series_top.sv]
// Top level of the arcsine-in-degrees block: configuration registers and
// the front, root and series parts. Depends on aeds_pkg and all submodules.
//
// One Q2.14 sine beat is taken at each edge where start is high and busy is
// low, every cycle if wanted; its Q8.8 degree result shows on angle_deg with
// done high for one cycle. The accepting edge loads the input queue, then
// 15 stages of the square root pipeline and 9 stages of the series and
// scaling pipeline (the last one being the result register) follow. busy
// rises only if the queue fills, which does not happen since the back end
// never stalls. Configuration writes are always ready and belong to idle
// periods.
module arcsin_degrees_series_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   sine_in,
  output logic                 busy,
  output logic                 done,
  output logic signed [15:0]   angle_deg,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  aeds_pkg::cfg_t     cfg;
  logic               q_valid;
  aeds_pkg::item_t    q_item;
  logic               r_valid;
  aeds_pkg::cls_t     r_cls;
  logic signed [15:0] r_x;
  logic [14:0]        r_root;

  assign cfg_ready = 1'b1;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clamp_high   <= 16'sd16384;
      cfg.clamp_low    <= -16'sd16384;
      cfg.band_high    <= 16'sd11585;
      cfg.band_low     <= -16'sd11585;
      cfg.coef_cubic   <= 16'd10923;
      cfg.coef_fifth   <= 16'd4915;
      cfg.coef_seventh <= 16'd2926;
      cfg.coef_ninth   <= 16'd1991;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aeds_pkg::REG_CLAMP_HIGH:   cfg.clamp_high   <= cfg_data;
        aeds_pkg::REG_CLAMP_LOW:    cfg.clamp_low    <= cfg_data;
        aeds_pkg::REG_BAND_HIGH:    cfg.band_high    <= cfg_data;
        aeds_pkg::REG_BAND_LOW:     cfg.band_low     <= cfg_data;
        aeds_pkg::REG_COEF_CUBIC:   cfg.coef_cubic   <= cfg_data;
        aeds_pkg::REG_COEF_FIFTH:   cfg.coef_fifth   <= cfg_data;
        aeds_pkg::REG_COEF_SEVENTH: cfg.coef_seventh <= cfg_data;
        aeds_pkg::REG_COEF_NINTH:   cfg.coef_ninth   <= cfg_data;
        default: ;
      endcase
    end
  end

  aeds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sine_in   (sine_in),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (q_valid),
    .out_item  (q_item)
  );

  aeds_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (r_valid),
    .out_cls   (r_cls),
    .out_x     (r_x),
    .out_root  (r_root)
  );

  aeds_series u_series (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_cls    (r_cls),
    .in_x      (r_x),
    .in_root   (r_root),
    .cfg       (cfg),
    .done      (done),
    .angle_deg (angle_deg)
  );

endmodule

[hdl/aeds_checker.sv]
// Port-level checks for the arcsine-in-degrees block, with its bind.
// Depends on arcsin_degrees_series_top.
module aeds_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] angle_deg
);

  // every accepted beat gives its result a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##25 done)
    else $error("result missing after fixed latency");

  // results stay within plus or minus ninety degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_deg <= 16'sd23040 && angle_deg >= -16'sd23040))
    else $error("angle out of range");

  // back end never stalls, so the queue never fills
  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("input queue filled");

  // reset flushes results in flight
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result after reset");

endmodule

bind arcsin_degrees_series_top aeds_checker u_aeds_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .angle_deg (angle_deg)
);
